/* hdl/bilinear_grid_interpolator_top_assert.svh */
// assertion macros used by the interpolator top
`ifndef BILINEAR_GRID_INTERPOLATOR_TOP_ASSERT_SVH
`define BILINEAR_GRID_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BGI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bgi: same-cycle check failed");
// next-cycle implication
`define BGI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bgi: next-cycle check failed");
`else
`define BGI_ASSERT_IMP(label, ante, cons)
`define BGI_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* hdl/bgi_pkg.sv */
package bgi_pkg;

    localparam int VAL_W  = 32;
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        K_LOAD_X = 2'd0,
        K_LOAD_Y = 2'd1,
        K_LOAD_Z = 2'd2,
        K_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OUTSIDE    = 2'd1,
        ST_ZERO_WIDTH = 2'd2
    } t_status;

    localparam logic [1:0] CFG_X_COUNT = 2'd0;
    localparam logic [1:0] CFG_Y_COUNT = 2'd1;
    localparam logic [1:0] CFG_FILL    = 2'd2;

    typedef struct packed {
        logic outside;
        logic zero_width;
    } t_axis_flags;

endpackage

/* hdl/bgi_axis.sv */
module bgi_axis #(
    parameter int MAXP  = 32,
    parameter int STEPS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAXP)-1:0]       i_wr_addr,
    input  logic signed [bgi_pkg::VAL_W-1:0] i_wr_data,
    input  logic                          i_start,
    input  logic [5:0]                    i_count,
    input  logic signed [bgi_pkg::VAL_W-1:0] i_query,
    output logic                          o_valid,
    output logic [$clog2(MAXP)-1:0]       o_index,
    output logic [bgi_pkg::FRAC_W-1:0]    o_frac,
    output bgi_pkg::t_axis_flags          o_flags
);
    import bgi_pkg::*;

    localparam int AW   = $clog2(MAXP);
    localparam int NW   = $clog2(MAXP + 1);
    localparam int IW   = NW + 1;
    localparam int CW   = (NW > 6) ? NW : 6;
    localparam int DIVS = FRAC_W;

    // count clamp
    logic [CW-1:0] count_ext;
    logic [NW-1:0] n_clamp;
    assign count_ext = CW'(i_count);
    always_comb begin
        if (count_ext < CW'(2)) begin
            n_clamp = NW'(2);
        end else if (count_ext > CW'(MAXP)) begin
            n_clamp = NW'(MAXP);
        end else begin
            n_clamp = count_ext[NW-1:0];
        end
    end

    // end points of the grid
    logic signed [VAL_W-1:0] mem_f [MAXP];
    logic                    r0_v;
    logic signed [VAL_W-1:0] r0_q, r0_g0, r0_gl;
    logic [NW-1:0]           r0_n;
    logic [NW-1:0]           n_m1;
    assign n_m1 = n_clamp - NW'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_f[i_wr_addr] <= i_wr_data;
        end
        r0_g0 <= mem_f[0];
        r0_gl <= mem_f[n_m1[AW-1:0]];
        r0_q  <= i_query;
        r0_n  <= n_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= i_start;
        end
    end

    // bisection stages
    logic                    r_v   [STEPS+1];
    logic signed [VAL_W-1:0] r_q   [STEPS+1];
    logic [NW-1:0]           r_n   [STEPS+1];
    logic                    r_asc [STEPS+1];
    logic                    r_eq0 [STEPS+1];
    logic                    r_eql [STEPS+1];
    logic signed [IW-1:0]    r_lo  [STEPS+1];
    logic signed [IW-1:0]    r_hi  [STEPS+1];
    logic signed [VAL_W-1:0] r_gm  [1:STEPS];
    logic signed [IW-1:0]    lo_u  [STEPS+1];
    logic signed [IW-1:0]    hi_u  [STEPS+1];

    always_ff @(posedge i_clk) begin
        r_q[0]   <= r0_q;
        r_n[0]   <= r0_n;
        r_asc[0] <= (r0_gl >= r0_g0);
        r_eq0[0] <= (r0_q == r0_g0);
        r_eql[0] <= (r0_q == r0_gl);
        r_lo[0]  <= '1;
        r_hi[0]  <= IW'(r0_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r0_v;
        end
    end

    assign lo_u[0] = r_lo[0];
    assign hi_u[0] = r_hi[0];

    for (genvar k = 1; k <= STEPS; k++) begin : g_upd
        logic signed [IW-1:0] mid;
        logic                 active;
        logic                 go_up;
        always_comb begin
            mid    = (r_lo[k] + r_hi[k]) >>> 1;
            active = (r_hi[k] - r_lo[k]) > IW'(1);
            go_up  = ((r_q[k] >= r_gm[k]) == r_asc[k]);
            lo_u[k] = r_lo[k];
            hi_u[k] = r_hi[k];
            if (active && go_up) begin
                lo_u[k] = mid;
            end else if (active) begin
                hi_u[k] = mid;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [VAL_W-1:0] mem_s [MAXP];
        logic signed [IW-1:0]    mid_n;
        assign mid_n = (lo_u[k] + hi_u[k]) >>> 1;

        always_ff @(posedge i_clk) begin
            if (i_wr_en) begin
                mem_s[i_wr_addr] <= i_wr_data;
            end
            r_gm[k+1]  <= mem_s[mid_n[AW-1:0]];
            r_q[k+1]   <= r_q[k];
            r_n[k+1]   <= r_n[k];
            r_asc[k+1] <= r_asc[k];
            r_eq0[k+1] <= r_eq0[k];
            r_eql[k+1] <= r_eql[k];
            r_lo[k+1]  <= lo_u[k];
            r_hi[k+1]  <= hi_u[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // interval pick and its two ends
    logic signed [IW-1:0]    idx_s;
    logic signed [IW-1:0]    n_s;
    logic                    out_s;
    logic [AW-1:0]           idx0, idx1;
    logic signed [VAL_W-1:0] mem_l [MAXP];
    logic                    rf_v, rf_out;
    logic [AW-1:0]           rf_idx;
    logic signed [VAL_W-1:0] rf_q, rf_a, rf_b;

    always_comb begin
        n_s = IW'(r_n[STEPS]);
        if (r_eq0[STEPS]) begin
            idx_s = '0;
        end else if (r_eql[STEPS]) begin
            idx_s = n_s - IW'(2);
        end else begin
            idx_s = lo_u[STEPS];
        end
        out_s = (idx_s < 0) || (idx_s >= n_s - IW'(1));
        idx0  = (idx_s < 0) ? '0 : idx_s[AW-1:0];
        idx1  = idx0 + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_l[i_wr_addr] <= i_wr_data;
        end
        rf_a   <= mem_l[idx0];
        rf_b   <= mem_l[idx1];
        rf_q   <= r_q[STEPS];
        rf_out <= out_s;
        rf_idx <= idx0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_v <= 1'b0;
        end else begin
            rf_v <= r_v[STEPS];
        end
    end

    // operand set-up and restoring divider, one quotient bit per stage
    logic signed [33:0] num_s, den_s;
    logic               dv_v    [DIVS+1];
    t_axis_flags        dv_fl   [DIVS+1];
    logic               dv_lo   [DIVS+1];
    logic               dv_hi   [DIVS+1];
    logic [AW-1:0]      dv_idx  [DIVS+1];
    logic [32:0]        dv_rem  [DIVS+1];
    logic [32:0]        dv_den  [DIVS+1];
    logic [FRAC_W-1:0]  dv_quo  [DIVS+1];

    always_comb begin
        num_s = 34'(rf_q) - 34'(rf_a);
        den_s = 34'(rf_b) - 34'(rf_a);
        if (den_s < 0) begin
            num_s = -num_s;
            den_s = -den_s;
        end
    end

    always_ff @(posedge i_clk) begin
        dv_fl[0].outside    <= rf_out;
        dv_fl[0].zero_width <= (rf_a == rf_b);
        dv_lo[0]  <= (num_s <= 0);
        dv_hi[0]  <= (num_s >= den_s);
        dv_idx[0] <= rf_idx;
        dv_rem[0] <= num_s[32:0];
        dv_den[0] <= den_s[32:0];
        dv_quo[0] <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else begin
            dv_v[0] <= rf_v;
        end
    end

    for (genvar k = 0; k < DIVS; k++) begin : g_div
        logic [33:0] rem2, diff;
        logic        ge;
        always_comb begin
            rem2 = {dv_rem[k], 1'b0};
            diff = rem2 - {1'b0, dv_den[k]};
            ge   = (rem2 >= {1'b0, dv_den[k]});
        end

        always_ff @(posedge i_clk) begin
            dv_rem[k+1] <= ge ? diff[32:0] : rem2[32:0];
            dv_quo[k+1] <= {dv_quo[k][FRAC_W-2:0], ge};
            dv_den[k+1] <= dv_den[k];
            dv_fl[k+1]  <= dv_fl[k];
            dv_lo[k+1]  <= dv_lo[k];
            dv_hi[k+1]  <= dv_hi[k];
            dv_idx[k+1] <= dv_idx[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[k+1] <= 1'b0;
            end else begin
                dv_v[k+1] <= dv_v[k];
            end
        end
    end

    // round to nearest, ties up, and clamp to one
    logic [FRAC_W:0]   q_inc;
    logic [FRAC_W-1:0] frac_n;
    always_comb begin
        q_inc = {1'b0, dv_quo[DIVS]} + (FRAC_W+1)'(1);
        if (dv_lo[DIVS]) begin
            frac_n = '0;
        end else if (dv_hi[DIVS]) begin
            frac_n = ONE_Q16;
        end else if (q_inc[FRAC_W:1] > ONE_Q16) begin
            frac_n = ONE_Q16;
        end else begin
            frac_n = q_inc[FRAC_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_frac  <= frac_n;
        o_index <= dv_idx[DIVS];
        o_flags <= dv_fl[DIVS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_v[DIVS];
        end
    end

endmodule

/* hdl/bilinear_grid_interpolator_top.sv */
// channel   | ports                                          | timing
// ----------+------------------------------------------------+---------------------------------
// request   | start, busy, i_kind, i_index_a/b, i_load_value,| taken when start and not busy
//           | i_query_x, i_query_y                           |
// result    | o_strobe, o_result_value, o_status             | one cycle, cannot be held off
// config    | i_cfg_we, i_cfg_idx, i_cfg_data                | written on any edge with i_cfg_we
//
// a query request can enter every cycle; its result reaches the result ports through the axis
// and blend pipelines and is taken at the edge after, STEPS being clog2(max points + 1):
// the bisection stages, one grid memory copy per stage, and the 17-stage divider set the depth
// load requests write the grids and table at acceptance and are held off by busy
// while any query is still in the pipeline, so earlier queries see the old contents
// synchronous active-low reset clears the valid bits, the in-flight count and the fill value
// and sets both point counts to 2; memory contents are undefined until written
`include "bilinear_grid_interpolator_top_assert.svh"

module bilinear_grid_interpolator_top #(
    parameter int MAX_X_POINTS = 32,
    parameter int MAX_Y_POINTS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_kind,
    input  logic [4:0]                       i_index_a,
    input  logic [4:0]                       i_index_b,
    input  logic signed [bgi_pkg::VAL_W-1:0] i_load_value,
    input  logic signed [bgi_pkg::VAL_W-1:0] i_query_x,
    input  logic signed [bgi_pkg::VAL_W-1:0] i_query_y,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [bgi_pkg::VAL_W-1:0]        i_cfg_data,
    output logic                             o_strobe,
    output logic signed [bgi_pkg::VAL_W-1:0] o_result_value,
    output logic [1:0]                       o_status
);
    import bgi_pkg::*;

    localparam int MAXP  = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int STEPS = $clog2(MAXP + 1);
    localparam int AWX   = $clog2(MAX_X_POINTS);
    localparam int AWY   = $clog2(MAX_Y_POINTS);
    localparam int ZD    = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int ZAW   = $clog2(ZD);
    localparam int LAT   = STEPS + 27;
    localparam int FW    = $clog2(LAT + 2);

    // config registers
    logic [5:0]              r_x_count, r_y_count;
    logic signed [VAL_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count <= 6'd2;
            r_y_count <= 6'd2;
            r_fill    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_COUNT: r_x_count <= i_cfg_data[5:0];
                CFG_Y_COUNT: r_y_count <= i_cfg_data[5:0];
                CFG_FILL:    r_fill    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request decode
    logic accept, query_acc;
    logic wr_x, wr_y, wr_z;
    logic pending;
    logic [FW-1:0] r_inflight;

    assign pending   = (r_inflight != '0);
    assign busy      = (i_kind != K_QUERY) && pending;
    assign accept    = start && !busy;
    assign query_acc = accept && (i_kind == K_QUERY);
    assign wr_x = accept && (i_kind == K_LOAD_X) && (32'(i_index_a) < 32'(MAX_X_POINTS));
    assign wr_y = accept && (i_kind == K_LOAD_Y) && (32'(i_index_a) < 32'(MAX_Y_POINTS));
    assign wr_z = accept && (i_kind == K_LOAD_Z) && (32'(i_index_a) < 32'(MAX_X_POINTS))
                  && (32'(i_index_b) < 32'(MAX_Y_POINTS));

    // queries in the pipeline, used to hold loads off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + FW'(query_acc) - FW'(o_strobe);
        end
    end

    // per-axis search and fraction
    logic              ax_v, ay_v;
    logic [AWX-1:0]    ax_idx;
    logic [AWY-1:0]    ay_idx;
    logic [FRAC_W-1:0] ax_frac, ay_frac;
    t_axis_flags       ax_fl, ay_fl;

    bgi_axis #(.MAXP(MAX_X_POINTS), .STEPS(STEPS)) u_axis_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_x),
        .i_wr_addr (AWX'(i_index_a)),
        .i_wr_data (i_load_value),
        .i_start   (query_acc),
        .i_count   (r_x_count),
        .i_query   (i_query_x),
        .o_valid   (ax_v),
        .o_index   (ax_idx),
        .o_frac    (ax_frac),
        .o_flags   (ax_fl)
    );

    bgi_axis #(.MAXP(MAX_Y_POINTS), .STEPS(STEPS)) u_axis_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_y),
        .i_wr_addr (AWY'(i_index_a)),
        .i_wr_data (i_load_value),
        .i_start   (query_acc),
        .i_count   (r_y_count),
        .i_query   (i_query_y),
        .o_valid   (ay_v),
        .o_index   (ay_idx),
        .o_frac    (ay_frac),
        .o_flags   (ay_fl)
    );

    // z table: two copies, one per x row of the cell, two read ports each
    logic signed [VAL_W-1:0] mem_za [ZD];
    logic signed [VAL_W-1:0] mem_zb [ZD];
    logic [ZAW:0] wr_za, a00, a01, a10, a11;

    always_comb begin
        wr_za = (ZAW+1)'(i_index_a) * (ZAW+1)'(MAX_Y_POINTS) + (ZAW+1)'(i_index_b);
        a00   = (ZAW+1)'(ax_idx) * (ZAW+1)'(MAX_Y_POINTS) + (ZAW+1)'(ay_idx);
        a01   = a00 + (ZAW+1)'(1);
        a10   = a00 + (ZAW+1)'(MAX_Y_POINTS);
        a11   = a10 + (ZAW+1)'(1);
    end

    // stage 1: corner reads
    logic                    r1_v;
    logic signed [VAL_W-1:0] r1_z00, r1_z01, r1_z10, r1_z11;
    logic [FRAC_W-1:0]       r1_u, r1_w;
    t_axis_flags             r1_fx, r1_fy;

    always_ff @(posedge i_clk) begin
        if (wr_z) begin
            mem_za[wr_za[ZAW-1:0]] <= i_load_value;
            mem_zb[wr_za[ZAW-1:0]] <= i_load_value;
        end
        r1_z00 <= mem_za[a00[ZAW-1:0]];
        r1_z01 <= mem_za[a01[ZAW-1:0]];
        r1_z10 <= mem_zb[a10[ZAW-1:0]];
        r1_z11 <= mem_zb[a11[ZAW-1:0]];
        r1_u   <= ax_frac;
        r1_w   <= ay_frac;
        r1_fx  <= ax_fl;
        r1_fy  <= ay_fl;
    end

    // stage 2: corner weights, summing to one in Q1.32
    logic [FRAC_W-1:0]       iu, iv;
    logic                    r2_v;
    logic [32:0]             r2_w00, r2_w01, r2_w10, r2_w11;
    logic signed [VAL_W-1:0] r2_z00, r2_z01, r2_z10, r2_z11;
    t_axis_flags             r2_fx, r2_fy;

    assign iu = ONE_Q16 - r1_u;
    assign iv = ONE_Q16 - r1_w;

    always_ff @(posedge i_clk) begin
        r2_w00 <= 33'(iu) * 33'(iv);
        r2_w01 <= 33'(iu) * 33'(r1_w);
        r2_w10 <= 33'(r1_u) * 33'(iv);
        r2_w11 <= 33'(r1_u) * 33'(r1_w);
        r2_z00 <= r1_z00;
        r2_z01 <= r1_z01;
        r2_z10 <= r1_z10;
        r2_z11 <= r1_z11;
        r2_fx  <= r1_fx;
        r2_fy  <= r1_fy;
    end

    // stage 3: weighted corners
    logic               r3_v;
    logic signed [65:0] r3_p00, r3_p01, r3_p10, r3_p11;
    t_axis_flags        r3_fx, r3_fy;

    always_ff @(posedge i_clk) begin
        r3_p00 <= $signed({1'b0, r2_w00}) * r2_z00;
        r3_p01 <= $signed({1'b0, r2_w01}) * r2_z01;
        r3_p10 <= $signed({1'b0, r2_w10}) * r2_z10;
        r3_p11 <= $signed({1'b0, r2_w11}) * r2_z11;
        r3_fx  <= r2_fx;
        r3_fy  <= r2_fy;
    end

    // stage 4: sum
    logic               r4_v;
    logic signed [65:0] r4_sum;
    t_axis_flags        r4_fx, r4_fy;

    always_ff @(posedge i_clk) begin
        r4_sum <= r3_p00 + r3_p01 + r3_p10 + r3_p11;
        r4_fx  <= r3_fx;
        r4_fy  <= r3_fy;
    end

    // stage 5: round, saturate, pick the error answer
    logic signed [65:0]      rnd;
    logic signed [33:0]      shr;
    logic signed [VAL_W-1:0] sat;
    logic signed [VAL_W-1:0] n_value;
    t_status                 n_status;

    always_comb begin
        rnd = r4_sum + 66'sd2147483648;
        shr = rnd[65:32];
        if (shr > 34'sd2147483647) begin
            sat = 32'sh7fffffff;
        end else if (shr < -34'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = shr[31:0];
        end
        if (r4_fx.outside || r4_fy.outside) begin
            n_value  = r_fill;
            n_status = ST_OUTSIDE;
        end else if (r4_fx.zero_width || r4_fy.zero_width) begin
            n_value  = r_fill;
            n_status = ST_ZERO_WIDTH;
        end else begin
            n_value  = sat;
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_value <= n_value;
        o_status       <= n_status;
    end

    // valid bits for the blend stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r1_v     <= ax_v && ay_v;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            o_strobe <= r4_v;
        end
    end

    `BGI_ASSERT_IMP(a_strobe_counted, o_strobe, r_inflight != '0)
    `BGI_ASSERT_NXT(a_query_counted, query_acc, r_inflight != '0)
    `BGI_ASSERT_IMP(a_load_when_empty, accept && (i_kind != K_QUERY), r_inflight == '0)
    `BGI_ASSERT_IMP(a_error_gives_fill, o_strobe && (o_status != ST_OK), o_result_value == r_fill)
    `BGI_ASSERT_IMP(a_axes_aligned, ax_v, ay_v)

endmodule
